[sv/mntl_pkg.sv]
// mntl_pkg: shared types and constants for the midi note to led tracker
// holds the parse phase enum, the note table and the result struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mntl_pkg;

  localparam int unsigned NumLeds  = 20;
  localparam int unsigned LedW     = 5;
  localparam int unsigned NoteW    = 7;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OutDataW = 24;

  // upper nibble codes of the status bytes we care about
  localparam logic [3:0] StatusNoteOn  = 4'h9;
  localparam logic [3:0] StatusNoteOff = 4'h8;

  typedef enum logic [1:0] {
    PH_WAIT_STATUS = 2'd0,
    PH_WAIT_NOTE   = 2'd1,
    PH_WAIT_VEL    = 2'd2
  } phase_e;

  typedef logic [NoteW-1:0] note_t;
  typedef logic [LedW-1:0]  led_t;

  // index 0 is the highest note
  localparam note_t NoteTable [NumLeds] = '{
    7'd74, 7'd73, 7'd72, 7'd71, 7'd69, 7'd67, 7'd66, 7'd65, 7'd64, 7'd62,
    7'd60, 7'd59, 7'd58, 7'd57, 7'd55, 7'd53, 7'd52, 7'd51, 7'd50, 7'd48
  };

  typedef struct packed {
    logic  is_note_on;
    note_t velocity;
    note_t note_number;
    led_t  led_index;
    logic  led_valid;
  } result_t;

endpackage

`default_nettype wire

[sv/mntl_note_lut.sv]
// mntl_note_lut: maps a note number to its led index
// twenty parallel compares against the table in mntl_pkg
`timescale 1ns / 1ps
`default_nettype none

module mntl_note_lut (
  input  mntl_pkg::note_t note_i,
  output logic            hit_o,
  output mntl_pkg::led_t  led_o
);
  import mntl_pkg::*;

  always_comb begin
    hit_o = 1'b0;
    led_o = '0;
    for (int i = 0; i < NumLeds; i++) begin
      if (NoteTable[i] == note_i) begin
        hit_o = 1'b1;
        led_o = LedW'(i);
      end
    end
  end

endmodule

`default_nettype wire

[sv/mntl_parser.sv]
// mntl_parser: running status note on/off parser and active led state
// uses mntl_pkg and mntl_note_lut; one byte handled per enabled cycle
`timescale 1ns / 1ps
`default_nettype none

module mntl_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [7:0]               rx_byte_i,
  output logic                     res_valid_o,
  output mntl_pkg::result_t        res_o
);
  import mntl_pkg::*;

  phase_e phase_q, phase_d;
  logic   status_on_q, status_on_d;
  note_t  held_note_q, held_note_d;
  logic   active_valid_q, active_valid_d;
  led_t   active_led_q, active_led_d;

  logic   hit;
  led_t   hit_led;
  note_t  vel;
  logic   on;

  mntl_note_lut u_lut (
    .note_i (held_note_q),
    .hit_o  (hit),
    .led_o  (hit_led)
  );

  assign vel = rx_byte_i[NoteW-1:0];
  assign on  = status_on_q && (vel != '0);

  always_comb begin
    phase_d        = phase_q;
    status_on_d    = status_on_q;
    held_note_d    = held_note_q;
    active_valid_d = active_valid_q;
    active_led_d   = active_led_q;
    res_valid_o    = 1'b0;
    if (step_i) begin
      if (rx_byte_i[7]) begin
        if (rx_byte_i[7:4] == StatusNoteOn || rx_byte_i[7:4] == StatusNoteOff) begin
          status_on_d = (rx_byte_i[7:4] == StatusNoteOn);
          phase_d     = PH_WAIT_NOTE;
        end else begin
          phase_d = PH_WAIT_STATUS;
        end
      end else begin
        case (phase_q)
          PH_WAIT_NOTE: begin
            held_note_d = rx_byte_i[NoteW-1:0];
            phase_d     = PH_WAIT_VEL;
          end
          PH_WAIT_VEL: begin
            phase_d     = PH_WAIT_NOTE;
            res_valid_o = 1'b1;
            if (on) begin
              active_valid_d = hit;
              active_led_d   = hit ? hit_led : '0;
            end else if (hit && active_valid_q && active_led_q == hit_led) begin
              active_valid_d = 1'b0;
              active_led_d   = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    res_o.led_valid   = active_valid_d;
    res_o.led_index   = active_valid_d ? active_led_d : '0;
    res_o.note_number = held_note_q;
    res_o.velocity    = vel;
    res_o.is_note_on  = on;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_WAIT_STATUS;
      status_on_q    <= 1'b0;
      held_note_q    <= '0;
      active_valid_q <= 1'b0;
      active_led_q   <= '0;
    end else begin
      phase_q        <= phase_d;
      status_on_q    <= status_on_d;
      held_note_q    <= held_note_d;
      active_valid_q <= active_valid_d;
      active_led_q   <= active_led_d;
    end
  end

endmodule

`default_nettype wire

[sv/midi_note_to_led_tracker_top.sv]
// midi_note_to_led_tracker_top: midi note on/off parser driving one active led index
// path: the velocity byte is held in the input register, and its result is then registered in the result register
// throughput: one byte per cycle; the input register moves whenever the
// result register is empty or being taken
// reset: asynchronous active low, parser waits for status, no led active
`timescale 1ns / 1ps
`default_nettype none

module midi_note_to_led_tracker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] led_valid, [5:1] led_index, [12:6] note_number, [19:13] velocity,
  // [20] is_note_on, [23:21] zero
  output logic [23:0] m_axis_tdata
);
  import mntl_pkg::*;

  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;
  logic              advance;
  logic              res_valid;
  result_t           res;

  // input stage moves on when the result register can take a new item
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  mntl_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_valid_q && advance),
    .rx_byte_i   (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - $bits(result_t))'(0), out_q};

  // the input side only stalls behind a full result register
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a pending result");

  a_index_zero_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_q.led_valid) |-> (out_q.led_index == '0))
    else $error("led index nonzero with no active led");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.led_index < LedW'(NumLeds)))
    else $error("led index out of range");

  a_note_on_has_velocity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.is_note_on) |-> (out_q.velocity != '0))
    else $error("note on reported with zero velocity");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// tb_top: self-checking bench for midi_note_to_led_tracker_top
// drives midi bytes on the input stream and checks each led result against a local tracker
// depends on mntl_pkg and midi_note_to_led_tracker_top
`timescale 1ns / 1ps

module tb_top;
  import mntl_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] led_valid, [5:1] led_index, [12:6] note_number, [19:13] velocity,
  // [20] is_note_on, [23:21] zero
  logic [23:0] m_axis_tdata;

  midi_note_to_led_tracker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // tracker copy of the parser and the active led
  phase_e  parse_ph;
  logic    status_on;
  note_t   held_note;
  logic    led_on;
  led_t    led_now;

  result_t expected_led_states[$];
  int      mismatches   = 0;
  int      bytes_used   = 0;
  bit      throttle_on  = 1'b0;

  function automatic int pick_gap();
    int r;
    if (!throttle_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 20);
  endfunction

  // steps the tracker by one byte; a data byte outside a message is ignored
  task automatic track_midi_byte(input logic [7:0] b, output bit ignored);
    result_t r;
    led_t    led;
    bit      hit;
    logic    on;
    note_t   vel;
    ignored = 1'b0;
    if (b[7]) begin
      if (b[7:4] == StatusNoteOn || b[7:4] == StatusNoteOff) begin
        status_on = (b[7:4] == StatusNoteOn);
        parse_ph  = PH_WAIT_NOTE;
      end else begin
        parse_ph = PH_WAIT_STATUS;
      end
    end else if (parse_ph == PH_WAIT_NOTE) begin
      held_note = b[6:0];
      parse_ph  = PH_WAIT_VEL;
    end else if (parse_ph == PH_WAIT_VEL) begin
      vel      = b[6:0];
      parse_ph = PH_WAIT_NOTE;
      hit      = 1'b0;
      led      = '0;
      for (int i = 0; i < NumLeds; i++) begin
        if (!hit && NoteTable[i] == held_note) begin
          hit = 1'b1;
          led = led_t'(i);
        end
      end
      on = status_on && (vel != '0);
      if (on) begin
        led_on  = hit;
        led_now = hit ? led : '0;
      end else if (hit && led_on && led_now == led) begin
        led_on  = 1'b0;
        led_now = '0;
      end
      r.led_valid   = led_on;
      r.led_index   = led_on ? led_now : '0;
      r.note_number = held_note;
      r.velocity    = vel;
      r.is_note_on  = on;
      expected_led_states.push_back(r);
    end else begin
      ignored = 1'b1;
    end
  endtask

  task automatic send_midi_byte(input logic [7:0] b);
    int gap;
    bit ignored;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_midi_byte(b, ignored);
    if (!ignored) begin
      bytes_used++;
    end
  endtask

  // receiver side stalls
  always @(posedge clk_i) begin
    int stall_left;
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (throttle_on && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_led_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected led result %h", m_axis_tdata);
        end
      end else begin
        want = expected_led_states.pop_front();
        if (m_axis_tdata[0] !== want.led_valid || m_axis_tdata[5:1] !== want.led_index ||
            m_axis_tdata[12:6] !== want.note_number ||
            m_axis_tdata[19:13] !== want.velocity ||
            m_axis_tdata[20] !== want.is_note_on || m_axis_tdata[23:21] !== 3'b000) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("led result mismatch: exp valid=%0d led=%0d note=%0d vel=%0d on=%0d",
                     want.led_valid, want.led_index, want.note_number, want.velocity,
                     want.is_note_on);
            $display("                      got valid=%0d led=%0d note=%0d vel=%0d on=%0d pad=%0d",
                     m_axis_tdata[0], m_axis_tdata[5:1], m_axis_tdata[12:6],
                     m_axis_tdata[19:13], m_axis_tdata[20], m_axis_tdata[23:21]);
          end
        end
      end
    end
  end

  task automatic test_directed_notes();
    logic [7:0] seq[$];
    throttle_on = 1'b1;
    // stray data bytes right after reset
    seq = {8'h7F, 8'h00};
    // highest note on, then lowest note under running status
    seq = {seq, 8'h90, 8'h4A, 8'h7F, 8'h30, 8'h01};
    // off for a note whose led is not active, then zero velocity on clears
    seq = {seq, 8'h8F, 8'h4A, 8'h00, 8'h9F, 8'h30, 8'h00};
    // unmapped off keeps the led, unmapped on clears it
    seq = {seq, 8'h90, 8'h3C, 8'h40, 8'h80, 8'h00, 8'h7F, 8'h90, 8'h7F, 8'h05};
    // real-time byte mid message, then a non-note status
    seq = {seq, 8'h90, 8'h3C, 8'hF8, 8'h3C, 8'hA5, 8'h3C};
    foreach (seq[i]) begin
      send_midi_byte(seq[i]);
    end
  endtask

  task automatic send_random_message();
    int   r;
    logic on;
    note_t note;
    note_t vel;
    r  = $urandom_range(0, 99);
    on = 1'($urandom_range(0, 1));
    if (r < 10) begin
      send_midi_byte(8'($urandom_range(0, 255)));
    end else if (r < 16) begin
      // message cut short by some other status
      send_midi_byte({on ? StatusNoteOn : StatusNoteOff, 4'($urandom_range(0, 15))});
      if ($urandom_range(0, 1)) begin
        send_midi_byte({1'b0, 7'($urandom_range(0, 127))});
      end
      send_midi_byte(8'($urandom_range(8'hA0, 8'hFF)));
    end else begin
      if (parse_ph != PH_WAIT_NOTE || $urandom_range(0, 1)) begin
        send_midi_byte({on ? StatusNoteOn : StatusNoteOff, 4'($urandom_range(0, 15))});
      end
      if (led_on && $urandom_range(0, 99) < 40) begin
        note = NoteTable[led_now];
      end else if ($urandom_range(0, 99) < 70) begin
        note = NoteTable[$urandom_range(0, NumLeds - 1)];
      end else begin
        note = 7'($urandom_range(0, 127));
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        vel = '0;
      end else if (r < 25) begin
        vel = 7'd127;
      end else begin
        vel = 7'($urandom_range(0, 127));
      end
      send_midi_byte({1'b0, note});
      send_midi_byte({1'b0, vel});
    end
  endtask

  task automatic test_random_with_idling(input int n_bytes);
    int stop_at;
    throttle_on = 1'b1;
    stop_at = bytes_used + n_bytes;
    while (bytes_used < stop_at) send_random_message();
  endtask

  task automatic test_back_to_back(input int n_bytes);
    int stop_at;
    throttle_on = 1'b0;
    stop_at = bytes_used + n_bytes;
    while (bytes_used < stop_at) send_random_message();
  endtask

  initial begin
    parse_ph  = PH_WAIT_STATUS;
    status_on = 1'b0;
    held_note = '0;
    led_on    = 1'b0;
    led_now   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_notes();
    test_random_with_idling(800);
    test_back_to_back(400);
    test_random_with_idling(450);

    s_axis_tvalid <= 1'b0;
    while (expected_led_states.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
